/* sv/nmea_rmc_time_extractor_assert.svh */
// Assertion macros shared by the checker of nmea_rmc_time_extractor.
// Depends on nothing; the including scope provides clk_i and rst_ni.
`ifndef NMEA_RMC_TIME_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_TIME_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NRTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NRTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nrte_pkg.sv */
// Package of the NMEA RMC time extractor: byte classes, queue item and result types.
// Used by nrte_front, nrte_back and the top level; depends on nothing.
`default_nettype none

package nrte_pkg;

  localparam int QueueDepth = 2;
  localparam int TimeChars  = 16;

  localparam logic [4:0] TimePosMax = 5'd31;
  localparam logic [3:0] TailComma  = 4'd11;
  localparam logic [3:0] FirstComma = 4'd1;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChG       = 8'h47;
  localparam logic [7:0] ChP       = 8'h50;
  localparam logic [7:0] ChR       = 8'h52;
  localparam logic [7:0] ChM       = 8'h4D;
  localparam logic [7:0] ChC       = 8'h43;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChNewline = 8'h0A;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_DOLLAR,
    CLS_G,
    CLS_P,
    CLS_R,
    CLS_M,
    CLS_C,
    CLS_COMMA,
    CLS_NEWLINE
  } byte_class_e;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_e cls;
  } item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] time_char;
    logic [3:0] char_index;
    logic       field_end;
    logic       done;
    logic       garbage;
  } result_t;

endpackage

`default_nettype wire

/* sv/nrte_front.sv */
// Front end: accepts received bytes, tags each with its character class, queues them.
// Depends on nrte_pkg.
`default_nettype none

module nrte_front
  import nrte_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  in_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output item_t       out_item_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  item_t          mem_q [DEPTH];
  item_t          item_in;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  always_comb begin
    item_in.data = in_data_i;
    case (in_data_i)
      ChDollar:  item_in.cls = CLS_DOLLAR;
      ChG:       item_in.cls = CLS_G;
      ChP:       item_in.cls = CLS_P;
      ChR:       item_in.cls = CLS_R;
      ChM:       item_in.cls = CLS_M;
      ChC:       item_in.cls = CLS_C;
      ChComma:   item_in.cls = CLS_COMMA;
      ChNewline: item_in.cls = CLS_NEWLINE;
      default:   item_in.cls = CLS_OTHER;
    endcase
  end

  assign in_ready_o  = (count_q != CntFull);
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

/* sv/nrte_back.sv */
// Back end: sentence parser state machine and the registered result slot.
// Depends on nrte_pkg.
`default_nettype none

module nrte_back
  import nrte_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         item_valid_i,
  output logic        item_ready_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output result_t     out_result_o
);

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_TALKER = 6'b000010,
    PH_ID     = 6'b000100,
    PH_FIELDS = 6'b001000,
    PH_TIME   = 6'b010000,
    PH_TAIL   = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hpos_q, hpos_d;
  logic [3:0]  comma_q, comma_d;
  logic [3:0]  comma_inc;
  logic [4:0]  tpos_q, tpos_d;
  logic        garb_q, garb_d;
  byte_class_e store_q [2];
  logic        store_we;
  logic        store_idx;
  logic        step;
  logic        out_valid_q;
  result_t     res_d, res_q;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign step         = item_valid_i && item_ready_o;
  assign comma_inc    = comma_q + 4'd1;

  always_comb begin
    phase_d   = phase_q;
    hpos_d    = hpos_q;
    comma_d   = comma_q;
    tpos_d    = tpos_q;
    garb_d    = garb_q;
    store_we  = 1'b0;
    store_idx = 1'b0;
    res_d     = '0;
    case (phase_q)
      PH_TALKER: begin
        if (hpos_q == 2'd0) begin
          store_we = 1'b1;
          hpos_d   = 2'd1;
        end else begin
          if (store_q[0] == CLS_G && item_i.cls == CLS_P) begin
            garb_d  = 1'b0;
            phase_d = PH_ID;
          end else begin
            garb_d  = 1'b1;
            phase_d = PH_HUNT;
          end
          hpos_d = 2'd0;
        end
      end
      PH_ID: begin
        if (hpos_q < 2'd2) begin
          store_we  = 1'b1;
          store_idx = hpos_q[0];
          hpos_d    = hpos_q + 2'd1;
        end else begin
          if (store_q[0] == CLS_R && store_q[1] == CLS_M && item_i.cls == CLS_C) begin
            phase_d = PH_FIELDS;
            comma_d = '0;
          end else begin
            phase_d = PH_HUNT;
          end
          hpos_d = 2'd0;
        end
      end
      PH_FIELDS: begin
        if (item_i.cls == CLS_COMMA) begin
          comma_d = comma_inc;
          if (comma_inc == FirstComma) begin
            phase_d = PH_TIME;
            tpos_d  = '0;
          end else if (comma_inc == TailComma) begin
            comma_d = '0;
            phase_d = PH_TAIL;
          end
        end
      end
      PH_TIME: begin
        if (item_i.cls == CLS_COMMA) begin
          res_d.field_end = 1'b1;
          comma_d         = comma_inc;
          phase_d         = PH_FIELDS;
          if (comma_inc == TailComma) begin
            comma_d = '0;
            phase_d = PH_TAIL;
          end
        end else begin
          // characters past the store size are dropped
          if (32'(tpos_q) < TimeChars && tpos_q < TimePosMax) begin
            res_d.char_valid = 1'b1;
            res_d.time_char  = item_i.data;
            res_d.char_index = tpos_q[3:0];
          end
          if (tpos_q < TimePosMax) begin
            tpos_d = tpos_q + 5'd1;
          end
        end
      end
      PH_TAIL: begin
        if (item_i.cls == CLS_NEWLINE) begin
          res_d.done = 1'b1;
          phase_d    = PH_HUNT;
          comma_d    = '0;
        end
      end
      default: begin
        if (item_i.cls == CLS_DOLLAR) begin
          phase_d = PH_TALKER;
          hpos_d  = 2'd0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
    res_d.garbage = garb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      hpos_q      <= '0;
      comma_q     <= '0;
      tpos_q      <= '0;
      garb_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        hpos_q  <= hpos_d;
        comma_q <= comma_d;
        tpos_q  <= tpos_d;
        garb_q  <= garb_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
      if (store_we) begin
        store_q[store_idx] <= item_i.cls;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;

endmodule

`default_nettype wire

/* sv/nmea_rmc_time_extractor.sv */
// Top level of the NMEA RMC time extractor: stream ports, front end and back end.
// Depends on nrte_pkg, nrte_front and nrte_back.
`default_nettype none

// One received NMEA byte enters per transfer on the slave stream and every byte yields
// exactly one result transfer on the master stream. The block hunts for '$', checks the
// talker (must be GP; any other talker sets the sticky garbage flag, GP clears it) and
// the sentence id (must be RMC), then counts commas. Each character of the time field
// comes out with tuser high, its byte and its position; the comma closing the time field
// sets the field-end bit, and the newline after the eleventh comma raises tlast.
// The block takes one byte per clock cycle while the master side is ready. An accepted
// byte is classified and written into the front-end queue, taken from there by the
// parser, and its result is held in the output register until taken. The front-end
// queue holds QUEUE_DEPTH bytes, so up to QUEUE_DEPTH + 1 bytes are in flight while the
// master side stalls, and s_axis_tready drops only when the queue is full. Time
// characters at positions past the store size (TimeChars in the package) are dropped;
// the position counter holds at 31. No reset sweep is needed: the block takes bytes
// right after reset.
module nmea_rmc_time_extractor
  import nrte_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] time_char, [11:8] time_char_index, [12] time_field_end,
  // [13] garbage_seen, [15:14] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] time_char_valid
  output logic        m_axis_tlast    // sentence_done
);

  // front-to-back queue handshake
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  result_t result;

  nrte_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  // Parser and output register; a result transfer frees the slot for the next byte.
  nrte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result)
  );

  assign m_axis_tdata = {2'b00, result.garbage, result.field_end,
                         result.char_index, result.time_char};
  assign m_axis_tuser = result.char_valid;
  assign m_axis_tlast = result.done;

endmodule

`default_nettype wire

/* sv/nrte_checker.sv */
// Port-level checker of nmea_rmc_time_extractor, bound to the top level below.
// Depends on nmea_rmc_time_extractor_assert.svh.
`default_nettype none

`include "nmea_rmc_time_extractor_assert.svh"

module nrte_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_tvalid_i,
  input wire        m_tready_i,
  input wire [15:0] m_tdata_i,
  input wire        m_tuser_i,
  input wire        m_tlast_i
);

  // a stalled result holds
  `NRTE_ASSERT_NEXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i) && $stable(m_tlast_i), "result changed while stalled")

  // no time character means zero byte and zero index
  `NRTE_ASSERT_NOW(a_char_zero, m_tvalid_i && !m_tuser_i, m_tdata_i[11:0] == 12'h000, "time char bits set without char flag")

  // a byte is at most one of: time character, field-end comma, sentence end
  `NRTE_ASSERT_NOW(a_kind_excl, m_tvalid_i, $countones({m_tuser_i, m_tdata_i[12], m_tlast_i}) <= 1, "result marks more than one kind")

  // all RMC events follow a GP talker, which cleared the garbage flag
  `NRTE_ASSERT_NOW(a_rmc_clean, m_tvalid_i && (m_tuser_i || m_tdata_i[12] || m_tlast_i), !m_tdata_i[13], "RMC event with garbage flag set")

endmodule

bind nmea_rmc_time_extractor nrte_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tuser_i  (m_axis_tuser),
  .m_tlast_i  (m_axis_tlast)
);

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for nmea_rmc_time_extractor: a byte-level RMC parser model
// predicts every result transfer, which is compared field by field on the master stream.
// Depends on nrte_pkg and the RTL of the block; it reads nothing else.
`timescale 1ns / 1ps

module testbench;
  import nrte_pkg::*;

  // Parser phases of the prediction model.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TALKER,
    PH_SENT_ID,
    PH_FIELDS,
    PH_TIME_FIELD,
    PH_TAIL
  } parse_phase_e;

  // Receiver stall styles; the stall generator picks a new one at random when its mode counter runs out.
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire         m_axis_tuser;
  wire         m_axis_tlast;

  // Model state.
  parse_phase_e phase_m   = PH_HUNT;
  logic [2:0]   hdr_pos_m = '0;
  logic [7:0]   hdr_m [2];
  logic [3:0]   commas_m  = '0;
  logic [4:0]   tpos_m    = '0;
  logic         garbage_m = 1'b0;

  result_t rmc_out_q [$];   // predicted result per accepted byte, oldest first
  result_t want_r;
  int      fail_count = 0;
  int      sent_count = 0;
  int      burst_left = 0;

  // Receiver stall generator state.
  rx_mode_e   rx_mode    = RX_STEADY;
  int         mode_left  = 0;
  int         long_stall = 0;
  logic [1:0] stall_phase = '0;

  always #10 clk_i = ~clk_i;

  nmea_rmc_time_extractor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Advances the parser model by one byte and returns the result it should produce.
  function automatic result_t rmc_parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (phase_m)
      PH_TALKER: begin
        if (hdr_pos_m == 3'd0) begin
          hdr_m[0]  = b;
          hdr_pos_m = 3'd1;
        end else begin
          if (hdr_m[0] == ChG && b == ChP) begin
            garbage_m = 1'b0;
            phase_m   = PH_SENT_ID;
          end else begin
            garbage_m = 1'b1;
            phase_m   = PH_HUNT;
          end
          hdr_pos_m = 3'd0;
        end
      end
      PH_SENT_ID: begin
        if (hdr_pos_m < 3'd2) begin
          hdr_m[hdr_pos_m[0]] = b;
          hdr_pos_m = hdr_pos_m + 3'd1;
        end else begin
          if (hdr_m[0] == ChR && hdr_m[1] == ChM && b == ChC) begin
            phase_m  = PH_FIELDS;
            commas_m = '0;
          end else begin
            phase_m = PH_HUNT;
          end
          hdr_pos_m = 3'd0;
        end
      end
      PH_FIELDS: begin
        if (b == ChComma) begin
          commas_m = commas_m + 4'd1;
          if (commas_m == FirstComma) begin
            phase_m = PH_TIME_FIELD;
            tpos_m  = '0;
          end else if (commas_m == TailComma) begin
            commas_m = '0;
            phase_m  = PH_TAIL;
          end
        end
      end
      PH_TIME_FIELD: begin
        if (b == ChComma) begin
          r.field_end = 1'b1;
          commas_m    = commas_m + 4'd1;
          phase_m     = PH_FIELDS;
          if (commas_m == TailComma) begin
            commas_m = '0;
            phase_m  = PH_TAIL;
          end
        end else begin
          // characters past the store size are swallowed; the position saturates at 31
          if (tpos_m < TimeChars && tpos_m < TimePosMax) begin
            r.char_valid = 1'b1;
            r.time_char  = b;
            r.char_index = tpos_m[3:0];
          end
          if (tpos_m < TimePosMax) tpos_m = tpos_m + 5'd1;
        end
      end
      PH_TAIL: begin
        if (b == ChNewline) begin
          r.done   = 1'b1;
          phase_m  = PH_HUNT;
          commas_m = '0;
        end
      end
      default: begin
        if (b == ChDollar) begin
          phase_m   = PH_TALKER;
          hdr_pos_m = 3'd0;
        end else begin
          phase_m = PH_HUNT;
        end
      end
    endcase
    r.garbage = garbage_m;
    return r;
  endfunction

  // Sends one byte; the sender runs in bursts with random idle gaps in between.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    rmc_out_q.push_back(rmc_parse_byte(b));
    burst_left--;
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Mostly digits and dots, now and then any byte except the field separator.
  function automatic logic [7:0] field_char();
    int         k;
    logic [7:0] b;
    k = $urandom_range(0, 9);
    if (k < 6) return 8'h30 + 8'($urandom_range(0, 9));
    if (k < 7) return 8'h2E;
    do b = 8'($urandom_range(0, 255)); while (b == ChComma);
    return b;
  endfunction

  // Well-formed RMC sentence with a time field of tlen characters and random content.
  task automatic send_rmc(input int tlen);
    logic [7:0] b;
    send_text("$GPRMC,");
    repeat (tlen) send_byte(field_char());
    send_byte(ChComma);
    // nine more commas take the count to eleven
    repeat (9) begin
      repeat ($urandom_range(0, 3)) send_byte(field_char());
      send_byte(ChComma);
    end
    // checksum-like tail, never a newline until the end
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom_range(0, 255));
      if (b == ChNewline) b = 8'h2A;
      send_byte(b);
    end
    send_byte(ChNewline);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Talker other than GP sets the sticky flag; GP with a wrong sentence id clears it
  // and goes back to hunting.
  task automatic test_header_rejects();
    send_text("$GL");
    send_text("$GPRMX");
  endtask

  // Complete sentence with all other fields empty: time field with NUL, '$', newline and 0xFF as content.
  task automatic test_time_capture();
    send_text("$GPRMC,");
    send_byte(8'h00);
    send_byte(ChDollar);
    send_byte(ChNewline);
    send_byte(8'hFF);
    repeat (10) send_byte(ChComma);
    send_byte(ChNewline);
  endtask

  // Time fields at and past the store size, and past the position limit.
  task automatic test_time_overflow();
    send_rmc(TimeChars);
    send_rmc(TimeChars + 1);
    send_rmc(40);
  endtask

  // Mostly good RMC sentences, the rest noise, bad headers, other sentences and
  // sentences cut short.
  task automatic test_random_stream();
    int         start;
    int         kind;
    int         k;
    int         pos;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] id_bytes [3];
    start = sent_count;
    while (sent_count - start < 600) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        k = $urandom_range(0, 19);
        if (k < 14)      send_rmc($urandom_range(0, 10));
        else if (k < 17) send_rmc($urandom_range(11, 20));
        else             send_rmc($urandom_range(21, 40));
      end else if (kind < 73) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 81) begin
        b0 = ($urandom_range(0, 3) == 0) ? ChG : 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        if (b0 == ChG && b1 == ChP) b1 = 8'h4C;
        send_byte(ChDollar);
        send_byte(b0);
        send_byte(b1);
      end else if (kind < 89) begin
        id_bytes = '{ChR, ChM, ChC};
        pos = $urandom_range(0, 2);
        b0  = 8'($urandom_range(0, 255));
        id_bytes[pos] = (b0 == id_bytes[pos]) ? b0 ^ 8'h01 : b0;
        send_text("$GP");
        foreach (id_bytes[i]) send_byte(id_bytes[i]);
      end else if (kind < 95) begin
        send_text("$GPGGA,");
        repeat ($urandom_range(1, 6)) send_byte(field_char());
        send_byte(ChNewline);
      end else begin
        // cut short: the parser stays inside the sentence and swallows what follows
        send_text("$GPRMC,");
        repeat ($urandom_range(0, 8)) send_byte(field_char());
        send_byte(ChNewline);
      end
    end
  endtask

  // Receiver stalls: steady, coin toss, one stall in four, or rare long stalls.
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 2'd1;
    case (rx_mode)
      RX_STEADY:   m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_axis_tready <= (stall_phase != 2'd3);
      default: begin
        if (long_stall != 0) begin
          long_stall    <= long_stall - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          long_stall    <= $urandom_range(1, 20);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Result check on every master-side transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rmc_out_q.size() == 0) begin
        note_failure($sformatf("%0t: result transfer with none expected, tdata=%04h",
                               $time, m_axis_tdata));
      end else begin
        want_r = rmc_out_q.pop_front();
        if (m_axis_tuser != want_r.char_valid || m_axis_tdata[7:0] != want_r.time_char ||
            m_axis_tdata[11:8] != want_r.char_index || m_axis_tdata[12] != want_r.field_end ||
            m_axis_tdata[13] != want_r.garbage || m_axis_tdata[15:14] != 2'b00 ||
            m_axis_tlast != want_r.done) begin
          note_failure($sformatf(
            "%0t: mismatch exp valid=%0b char=%02h idx=%0d end=%0b garb=%0b done=%0b pad=0 | got valid=%0b char=%02h idx=%0d end=%0b garb=%0b done=%0b pad=%0d",
            $time, want_r.char_valid, want_r.time_char, want_r.char_index, want_r.field_end,
            want_r.garbage, want_r.done, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
            m_axis_tdata[12], m_axis_tdata[13], m_axis_tlast, m_axis_tdata[15:14]));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_header_rejects();
    test_time_capture();
    test_time_overflow();
    test_random_stream();
    s_axis_tvalid <= 1'b0;
    // drain, then keep watching to catch stray results
    while (rmc_out_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
